// ===== src/pis_pkg.sv =====
// Package with the shared types and constants of the standardization core.
package pis_pkg;

	localparam int SampleW = 8;
	localparam int StdW    = 19;
	localparam int MeanW   = 20;
	localparam int InvW    = 24;
	localparam int StdMax  = 262143;
	localparam int StdMin  = -262144;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEAN,
		ST_VAR,
		ST_ROOT,
		ST_DRAIN_RD,
		ST_DRAIN_MUL,
		ST_DRAIN_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic restart;
		logic stats_start;
		logic var_start;
		logic root_start;
		logic drain_read;
		logic drain_mul;
		logic drain_take;
		logic error_out;
	} cmd_t;

	typedef struct packed {
		logic mean_done;
		logic var_done;
		logic root_done;
		logic stats_ready;
		logic drain_avail;
		logic count_full;
		logic count_zero;
		logic out_busy;
	} status_t;

	typedef struct packed {
		logic signed [StdW-1:0] std_value;
		logic                   last_value;
		logic                   drain_error;
	} result_t;

endpackage

// ===== src/pis_stream_if.sv =====
// Valid and ready channel interface that carries one payload per transfer.
interface pis_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== src/per_image_standardization_core.sv =====
// Top level of the per-image standardization core.
// Load transfers are accepted back to back. After the last load the core computes
// the mean, a restoring division that yields one quotient bit a cycle, and then
// runs the 24-step square root search, one bit of the reciprocal per pass; each
// pass squares the candidate and multiplies it by the variance term in four
// partial products. For an image of one sample the search is skipped. No transfer
// is accepted while the statistics are formed. A drain transfer passes through
// the sample RAM read, the subtract and the multiplier stage, and its result
// waits in an output register until it is taken; no further transfer is
// accepted while a result waits there.
module per_image_standardization_core #(
	parameter int MaxSamples = 4096
) (
	input logic clk,
	input logic arst_n,
	pis_stream_if.sink   in_ch,
	pis_stream_if.source out_ch
);
	pis_pkg::cmd_t cmd;
	pis_pkg::status_t status;
	pis_pkg::result_t res;

	pis_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid),
		.func(in_ch.payload[9]), .last_sample(in_ch.payload[0]),
		.status(status), .in_ready(in_ch.ready), .cmd(cmd)
	);

	pis_datapath #(.MaxSamples(MaxSamples)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sample(in_ch.payload[8:1]),
		.out_ready(out_ch.ready), .out_valid(out_ch.valid), .out_data(res),
		.status(status)
	);

	assign out_ch.payload = res;
endmodule

// ===== src/pis_ram.sv =====
// Generic single-port RAM with registered read data.
module pis_ram #(
	parameter int Width = 8,
	parameter int Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== src/pis_datapath.sv =====
// Datapath: sample store, accumulators, statistics units and the output stage.
module pis_datapath #(
	parameter int MaxSamples = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pis_pkg::cmd_t                 cmd,
	input  logic [pis_pkg::SampleW-1:0]   sample,
	input  logic                          out_ready,
	output logic                          out_valid,
	output pis_pkg::result_t              out_data,
	output pis_pkg::status_t              status
);
	localparam int CntW = $clog2(MaxSamples + 1);
	localparam int AddrW = $clog2(MaxSamples);
	localparam int SumW = CntW + 8;
	localparam int SqW = CntW + 16;
	localparam int NumW = SumW + 12;
	localparam int DW = CntW + SqW;
	localparam int DHalf = (DW + 1) / 2;
	localparam int NnW = 2 * CntW;
	localparam int RhsW = NnW + 34;
	localparam int ProdW = 48 + DW;

	logic [CntW-1:0] count_q, drain_q;
	logic [SumW-1:0] sum_q;
	logic [SqW-1:0] sq_q;
	logic [pis_pkg::MeanW-1:0] mean_q;
	logic [pis_pkg::InvW-1:0] inv_q;
	logic ready_q;

	logic [AddrW-1:0] addr;
	logic [7:0] rdata;
	logic ram_we;

	assign ram_we = cmd.load && !(count_q == CntW'(MaxSamples) && !cmd.restart);
	assign addr = cmd.load ? (cmd.restart ? '0 : count_q[AddrW-1:0]) : drain_q[AddrW-1:0];

	pis_ram #(.Width(8), .Depth(MaxSamples)) u_ram (
		.clk(clk), .we(ram_we), .addr(addr), .wdata(sample), .rdata(rdata)
	);

	// Mean: restoring division, one quotient bit per cycle.
	logic [NumW-1:0] num_q, quo_q;
	logic [CntW:0] rem_q;
	logic [$clog2(NumW+1)-1:0] mstep_q;
	logic mbusy_q;
	logic [CntW+1:0] rem_sh;

	// Variance: D = n*sq - sum^2, floored at n-1; the products are registered first, then the difference, then the floor.
	logic [DW-1:0] nq_q, s2_q, d_q;
	logic [NnW-1:0] nn_q;
	logic [1:0] vstep_q;
	logic vbusy_q;

	// Root: one bit of r per pass; each pass squares the candidate and builds
	// the product with D from four partial products, one per cycle.
	logic [pis_pkg::InvW-1:0] r_q, cand_q;
	logic [47:0] csq_q;
	logic [ProdW-1:0] prod_q;
	logic [4:0] bit_q;
	logic [2:0] rphase_q;
	logic rbusy_q;
	logic [RhsW-1:0] rhs;
	logic [23:0] pp_a;
	logic [DHalf-1:0] pp_b;
	logic [23+DHalf:0] pp;
	logic [ProdW-1:0] pp_ext;

	logic signed [21:0] diff_s1;
	logic signed [46:0] prod_s2;
	logic last_s1, last_s2;
	logic signed [47:0] rnd;
	logic signed [29:0] val;
	logic signed [pis_pkg::StdW-1:0] sat;

	assign rem_sh = {rem_q, num_q[NumW-1]};
	assign rhs = {nn_q, 34'd0};

	always_comb begin
		pp_a = rphase_q[2] ? csq_q[47:24] : csq_q[23:0];
		pp_b = rphase_q[0] ? DHalf'(d_q[DW-1:DHalf]) : d_q[DHalf-1:0];
		pp = pp_a * pp_b;
		pp_ext = ProdW'(pp) << ((rphase_q[2] ? 24 : 0) + (rphase_q[0] ? DHalf : 0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drain_q <= '0;
			sum_q <= '0;
			sq_q <= '0;
			mean_q <= '0;
			inv_q <= '0;
			ready_q <= 1'b0;
			mbusy_q <= 1'b0;
			vbusy_q <= 1'b0;
			rbusy_q <= 1'b0;
			out_valid <= 1'b0;
			mstep_q <= '0;
			vstep_q <= '0;
			bit_q <= '0;
			rphase_q <= '0;
		end else begin
			if (cmd.load) begin
				if (cmd.restart) begin
					count_q <= CntW'(1);
					sum_q <= SumW'(sample);
					sq_q <= SqW'(sample) * SqW'(sample);
					drain_q <= '0;
					ready_q <= 1'b0;
				end else if (ram_we) begin
					count_q <= count_q + 1'b1;
					sum_q <= sum_q + SumW'(sample);
					sq_q <= sq_q + SqW'(sample) * SqW'(sample);
				end
			end
			if (cmd.stats_start) begin
				mbusy_q <= 1'b1;
				num_q <= {sum_q, 12'd0} + NumW'(count_q >> 1);
				quo_q <= '0;
				rem_q <= '0;
				mstep_q <= '0;
			end else if (mbusy_q) begin
				if (rem_sh >= {2'b0, count_q}) begin
					rem_q <= (CntW+1)'(rem_sh - {2'b0, count_q});
					quo_q <= {quo_q[NumW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[CntW:0];
					quo_q <= {quo_q[NumW-2:0], 1'b0};
				end
				num_q <= {num_q[NumW-2:0], 1'b0};
				mstep_q <= mstep_q + 1'b1;
				if (mstep_q == ($clog2(NumW+1))'(NumW - 1)) begin
					mbusy_q <= 1'b0;
					mean_q <= pis_pkg::MeanW'({quo_q[NumW-2:0], rem_sh >= {2'b0, count_q}});
				end
			end
			if (cmd.var_start) begin
				vbusy_q <= 1'b1;
				vstep_q <= '0;
				nq_q <= DW'(count_q) * DW'(sq_q);
				s2_q <= DW'(sum_q) * DW'(sum_q);
				nn_q <= NnW'(count_q) * NnW'(count_q - 1'b1);
			end else if (vbusy_q) begin
				vstep_q <= vstep_q + 1'b1;
				if (vstep_q == 2'd0) begin
					d_q <= (nq_q > s2_q) ? nq_q - s2_q : '0;
				end else begin
					if (d_q < DW'(count_q - 1'b1)) begin
						d_q <= DW'(count_q - 1'b1);
					end
					vbusy_q <= 1'b0;
				end
			end
			if (cmd.root_start) begin
				if (count_q == CntW'(1)) begin
					inv_q <= pis_pkg::InvW'(131072);
					ready_q <= 1'b1;
					drain_q <= '0;
				end else begin
					rbusy_q <= 1'b1;
					r_q <= '0;
					bit_q <= 5'd23;
					rphase_q <= '0;
				end
			end else if (rbusy_q) begin
				rphase_q <= rphase_q + 1'b1;
				case (rphase_q)
					3'd0: cand_q <= r_q | (pis_pkg::InvW'(1) << bit_q);
					3'd1: begin
						csq_q <= cand_q * cand_q;
						prod_q <= '0;
					end
					3'd6: begin
						rphase_q <= '0;
						if (prod_q <= ProdW'(rhs)) begin
							r_q <= cand_q;
						end
						bit_q <= bit_q - 1'b1;
						if (bit_q == 5'd0) begin
							rbusy_q <= 1'b0;
							inv_q <= (prod_q <= ProdW'(rhs)) ? cand_q : r_q;
							ready_q <= 1'b1;
							drain_q <= '0;
						end
					end
					default: prod_q <= prod_q + pp_ext;
				endcase
			end
			if (cmd.drain_read) begin
				drain_q <= drain_q + 1'b1;
			end
			if (cmd.drain_take || cmd.error_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drain_read) begin
			last_s1 <= (drain_q + 1'b1 == count_q);
		end
		if (cmd.drain_mul) begin
			diff_s1 <= $signed({2'b0, rdata, 12'd0}) - $signed({2'b0, mean_q});
			last_s2 <= last_s1;
		end
		if (cmd.drain_take) begin
			out_data.std_value <= sat;
			out_data.last_value <= last_s2;
			out_data.drain_error <= 1'b0;
		end else if (cmd.error_out) begin
			out_data <= '{std_value: '0, last_value: 1'b0, drain_error: 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= diff_s1 * $signed({1'b0, inv_q});
	end

	always_comb begin
		rnd = 48'(prod_s2) + 48'sd131072;
		val = 30'(rnd >>> 18);
		if (val > 30'(pis_pkg::StdMax)) begin
			sat = pis_pkg::StdW'(pis_pkg::StdMax);
		end else if (val < 30'(pis_pkg::StdMin)) begin
			sat = pis_pkg::StdW'(pis_pkg::StdMin);
		end else begin
			sat = val[pis_pkg::StdW-1:0];
		end
	end

	assign status.mean_done = mbusy_q && mstep_q == ($clog2(NumW+1))'(NumW - 1)
		&& !cmd.stats_start;
	assign status.var_done = vbusy_q && vstep_q != 2'd0;
	assign status.root_done = !rbusy_q;
	assign status.stats_ready = ready_q;
	assign status.drain_avail = ready_q && drain_q < count_q;
	assign status.count_full = count_q == CntW'(MaxSamples);
	assign status.count_zero = count_q == '0;
	assign status.out_busy = out_valid && !out_ready;
endmodule

// ===== src/pis_ctrl.sv =====
// Controller state machine that sequences loads, statistics and drains.
module pis_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             func,
	input  logic             last_sample,
	input  pis_pkg::status_t status,
	output logic             in_ready,
	output pis_pkg::cmd_t    cmd
);
	pis_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pis_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			pis_pkg::ST_IDLE: begin
				in_ready = !status.out_busy;
				if (in_valid && in_ready) begin
					if (!func) begin
						cmd.load = 1'b1;
						cmd.restart = status.stats_ready;
						if (last_sample) begin
							state_d = pis_pkg::ST_MEAN;
						end
					end else if (status.drain_avail) begin
						cmd.drain_read = 1'b1;
						state_d = pis_pkg::ST_DRAIN_RD;
					end else begin
						cmd.error_out = 1'b1;
					end
				end
			end
			pis_pkg::ST_MEAN: begin
				if (status.count_zero) begin
					state_d = pis_pkg::ST_IDLE;
				end else begin
					cmd.stats_start = 1'b1;
					cmd.var_start = 1'b1;
					state_d = pis_pkg::ST_VAR;
				end
			end
			pis_pkg::ST_VAR: begin
				if (status.mean_done) begin
					cmd.root_start = 1'b1;
					state_d = pis_pkg::ST_ROOT;
				end
			end
			pis_pkg::ST_ROOT: begin
				if (status.root_done && status.stats_ready) begin
					state_d = pis_pkg::ST_IDLE;
				end
			end
			pis_pkg::ST_DRAIN_RD: begin
				cmd.drain_mul = 1'b1;
				state_d = pis_pkg::ST_DRAIN_MUL;
			end
			pis_pkg::ST_DRAIN_MUL: begin
				state_d = pis_pkg::ST_DRAIN_OUT;
			end
			pis_pkg::ST_DRAIN_OUT: begin
				cmd.drain_take = 1'b1;
				state_d = pis_pkg::ST_IDLE;
			end
			default: state_d = pis_pkg::ST_IDLE;
		endcase
	end
endmodule

// ===== dv/per_image_standardization_core_test.sv =====
// Self-checking testbench of the per-image standardization core: directed table, random images.
module per_image_standardization_core_test;

	localparam int StoreDepth = 4096;

	typedef enum logic {FN_LOAD = 1'b0, FN_DRAIN = 1'b1} func_e;

	typedef struct packed {
		logic                         func;
		logic [pis_pkg::SampleW-1:0]  sample;
		logic                         last_sample;
	} in_item_t;

	typedef struct {
		func_e                        fn;
		logic [pis_pkg::SampleW-1:0]  smp;
		logic                         lst;
		bit                           typed;
		pis_pkg::result_t             res;
	} row_t;

	logic clk;
	logic arst_n;

	pis_stream_if #(.payload_t(in_item_t))         in_ch ();
	pis_stream_if #(.payload_t(pis_pkg::result_t)) out_ch ();

	per_image_standardization_core #(.MaxSamples(StoreDepth)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Predictor state.
	logic [pis_pkg::SampleW-1:0] pix_mem [StoreDepth];
	int unsigned        pix_count;
	longint unsigned    pix_sum;
	longint unsigned    sq_sum;
	longint unsigned    mean_q12;
	longint unsigned    recip_dev;
	int unsigned        next_out;
	bit                 stats_valid;

	pis_pkg::result_t   pending_results[$];
	int                 fail_count;
	int                 results_seen;
	int                 error_results;
	int                 images_closed;
	int                 items_sent;
	int                 src_idle_pct;
	int                 snk_idle_pct;
	int                 hold_asks;
	int                 holds_taken;
	int                 hold_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("[per_image_standardization_core] ERROR");
		$finish;
	end

	function automatic void work_out_stats();
		longint unsigned n, nq, s2, d, nn, c;
		logic [127:0] rhs, lhs;
		longint unsigned r;
		n = pix_count;
		mean_q12 = ((pix_sum << 12) + n / 2) / n;
		if (n == 1) begin
			recip_dev = 131072;
		end else begin
			nq = n * sq_sum;
			s2 = pix_sum * pix_sum;
			d = (nq > s2) ? nq - s2 : 0;
			if (d < n - 1)
				d = n - 1;
			nn = n * (n - 1);
			rhs = {64'd0, nn} << 34;
			r = 0;
			for (int b = 23; b >= 0; b--) begin
				c = r | (64'd1 << b);
				lhs = {64'd0, c * c} * {64'd0, d};
				if (lhs <= rhs)
					r = c;
			end
			recip_dev = r;
		end
		next_out = 0;
		stats_valid = 1'b1;
		images_closed++;
	endfunction

	// Updates the predictor for one accepted item; returns 1 with the result when one is due.
	function automatic bit standardize(input in_item_t it, output pis_pkg::result_t res);
		longint signed diff, prod, val;
		res = '0;
		if (it.func == FN_LOAD) begin
			if (stats_valid) begin
				pix_count = 0;
				pix_sum = 0;
				sq_sum = 0;
				next_out = 0;
				stats_valid = 1'b0;
			end
			if (pix_count < StoreDepth) begin
				pix_mem[pix_count] = it.sample;
				pix_count++;
				pix_sum += it.sample;
				sq_sum += it.sample * it.sample;
			end
			if (it.last_sample && pix_count > 0)
				work_out_stats();
			return 1'b0;
		end
		if (!stats_valid || next_out >= pix_count) begin
			res.drain_error = 1'b1;
			return 1'b1;
		end
		diff = (longint'(pix_mem[next_out]) << 12) - longint'(mean_q12);
		prod = diff * longint'(recip_dev);
		val = (prod + (64'sd1 <<< 17)) >>> 18;
		if (val > pis_pkg::StdMax)
			val = pis_pkg::StdMax;
		if (val < pis_pkg::StdMin)
			val = pis_pkg::StdMin;
		res.std_value = val[pis_pkg::StdW-1:0];
		res.last_value = (next_out + 1 == pix_count);
		next_out++;
		return 1'b1;
	endfunction

	task automatic send(input in_item_t it, input bit typed, input pis_pkg::result_t typed_res);
		pis_pkg::result_t res;
		bit due;
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid = 1'b0;
			in_ch.payload = in_item_t'($urandom);
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.payload = it;
		do
			@(posedge clk);
		while (!in_ch.ready);
		due = standardize(it, res);
		if (due)
			pending_results.push_back(typed ? typed_res : res);
		items_sent++;
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	task automatic send_item(input func_e fn, input logic [pis_pkg::SampleW-1:0] smp,
			input logic lst);
		in_item_t it;
		it.func = fn;
		it.sample = smp;
		it.last_sample = lst;
		send(it, 1'b0, '0);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic random_image(input int n, input int extra_drains);
		int mode, base;
		logic [pis_pkg::SampleW-1:0] s;
		mode = $urandom_range(3);
		base = $urandom_range(255);
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: s = pis_pkg::SampleW'($urandom);
				1: s = pis_pkg::SampleW'(base + $urandom_range(3));
				2: s = pis_pkg::SampleW'(base);
				default: s = $urandom_range(1) ? 8'hff : 8'h00;
			endcase
			send_item(FN_LOAD, s, i == n - 1);
		end
		for (int i = 0; i < n + extra_drains; i++)
			send_item(FN_DRAIN, pis_pkg::SampleW'($urandom), 1'($urandom_range(1)));
	endtask

	task automatic random_phase(input int quota);
		int n;
		int stop_at;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 85) begin
				n = ($urandom_range(19) == 0) ? $urandom_range(300, 41) : $urandom_range(40, 1);
				random_image(n, $urandom_range(3) == 0 ? -($urandom_range(n - 1))
					: $urandom_range(2));
			end else begin
				repeat ($urandom_range(6, 1))
					send_item(func_e'($urandom_range(1)), pis_pkg::SampleW'($urandom),
						1'($urandom_range(1)));
			end
		end
	endtask

	always @(posedge clk) begin
		pis_pkg::result_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.payload;
			results_seen++;
			if (got.drain_error)
				error_results++;
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: std_value %0d", got.std_value);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.std_value !== want.std_value) begin
					$error("std_value expected %0d got %0d", want.std_value, got.std_value);
					fail_count++;
				end
				if (got.last_value !== want.last_value) begin
					$error("last_value expected %0b got %0b", want.last_value, got.last_value);
					fail_count++;
				end
				if (got.drain_error !== want.drain_error) begin
					$error("drain_error expected %0b got %0b", want.drain_error,
						got.drain_error);
					fail_count++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ch.ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (holds_taken != hold_asks) begin
			out_ch.ready <= 1'b0;
			hold_cycles <= 400;
			holds_taken <= holds_taken + 1;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	initial begin
		row_t rows[$];
		in_item_t it;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		fail_count = 0;
		results_seen = 0;
		error_results = 0;
		images_closed = 0;
		items_sent = 0;
		hold_asks = 0;
		src_idle_pct = 13;
		snk_idle_pct = 82;
		pix_count = 0;
		pix_sum = 0;
		sq_sum = 0;
		mean_q12 = 0;
		recip_dev = 0;
		next_out = 0;
		stats_valid = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		rows = '{
			'{FN_DRAIN, 8'hff, 1'b1, 1'b1, '{0, 1'b0, 1'b1}},
			'{FN_LOAD,  8'h00, 1'b1, 1'b0, '0},
			'{FN_DRAIN, 8'h00, 1'b0, 1'b1, '{0, 1'b1, 1'b0}},
			'{FN_DRAIN, 8'h00, 1'b0, 1'b1, '{0, 1'b0, 1'b1}},
			'{FN_LOAD,  8'hff, 1'b0, 1'b0, '0},
			'{FN_LOAD,  8'h00, 1'b1, 1'b0, '0},
			'{FN_DRAIN, 8'h00, 1'b0, 1'b0, '0},
			'{FN_DRAIN, 8'h00, 1'b0, 1'b0, '0},
			'{FN_DRAIN, 8'h00, 1'b0, 1'b1, '{0, 1'b0, 1'b1}},
			'{FN_LOAD,  8'h07, 1'b0, 1'b0, '0},
			'{FN_LOAD,  8'h07, 1'b0, 1'b0, '0},
			'{FN_LOAD,  8'h07, 1'b1, 1'b0, '0},
			'{FN_DRAIN, 8'h00, 1'b0, 1'b1, '{0, 1'b0, 1'b0}},
			'{FN_LOAD,  8'h00, 1'b0, 1'b0, '0},
			'{FN_LOAD,  8'h00, 1'b0, 1'b0, '0},
			'{FN_LOAD,  8'h00, 1'b0, 1'b0, '0},
			'{FN_LOAD,  8'hff, 1'b1, 1'b0, '0},
			'{FN_DRAIN, 8'h00, 1'b0, 1'b0, '0},
			'{FN_DRAIN, 8'h00, 1'b0, 1'b0, '0},
			'{FN_DRAIN, 8'h00, 1'b0, 1'b0, '0},
			'{FN_DRAIN, 8'h00, 1'b0, 1'b0, '0},
			'{FN_DRAIN, 8'h00, 1'b0, 1'b1, '{0, 1'b0, 1'b1}}
		};
		foreach (rows[i]) begin
			it.func = rows[i].fn;
			it.sample = rows[i].smp;
			it.last_sample = rows[i].lst;
			send(it, rows[i].typed, rows[i].res);
		end
		wait_drained();

		random_phase(560);
		wait_drained();

		src_idle_pct = 82;
		snk_idle_pct = 13;
		hold_asks++;
		src_idle_pct = 0;
		random_image(60, 0);
		src_idle_pct = 82;
		random_phase(560);
		wait_drained();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		random_phase(560);
		wait_drained();

		$display("Sent %0d items over %0d closed images; %0d results checked, %0d of them errors.",
			items_sent, images_closed, results_seen, error_results);
		if (fail_count == 0)
			$display("[per_image_standardization_core] OK");
		else
			$display("[per_image_standardization_core] ERROR");
		$finish;
	end

endmodule
